// ===== hdl/peta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peta_pkg
// Shared types and codes for the pending entry table with aging.
// ----------------------------------------------------------------------------
package peta_pkg;

   localparam int KEY_W = 64;
   localparam int ACCT_W = 64;
   localparam int PAY_W = 32;
   localparam int TICK_W = 32;
   localparam int LIMIT_W = 7;
   localparam int CNT_W = 7;
   localparam int STAT_W = 3;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;
   localparam logic [1:0] ACT_AGE = 2'd3;

   localparam logic [STAT_W-1:0] ST_DONE = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL = 3'd1;
   localparam logic [STAT_W-1:0] ST_LIMIT = 3'd2;
   localparam logic [STAT_W-1:0] ST_DUP = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STAT_W-1:0] ST_NONE_EXPIRED = 3'd5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd8;

   typedef struct packed {
      logic [1:0] action;
      logic [KEY_W-1:0] key;
      logic [ACCT_W-1:0] account;
      logic [PAY_W-1:0] payload;
      logic [TICK_W-1:0] now;
      logic [TICK_W-1:0] cutoff;
   } cmd_type;

   typedef struct packed {
      logic valid;
      cmd_type cmd;
   } cmd_link_type;

endpackage

// ===== hdl/peta_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peta_front
// Takes request transfers, works out the age cutoff and queues commands.
// ----------------------------------------------------------------------------
module peta_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [1:0]            in_action,
   input  logic [223:0]          in_data,
   output peta_pkg::cmd_link_type head,
   input  logic                  pop
);
   import peta_pkg::*;

   cmd_type q_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type cmd_in;
   logic push;
   logic do_pop;

   always_comb begin
      cmd_in.action = in_action;
      cmd_in.key = in_data[63:0];
      cmd_in.account = in_data[127:64];
      cmd_in.payload = in_data[159:128];
      cmd_in.now = in_data[191:160];
      cmd_in.cutoff = (in_data[191:160] >= in_data[223:192]) ?
                      in_data[191:160] - in_data[223:192] : '0;
   end

   assign in_ready = (count_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign do_pop = pop && (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.cmd = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/peta_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peta_back
// Table store and scan sequencer: insert, remove, query and age out.
// ----------------------------------------------------------------------------
module peta_back #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  peta_pkg::cmd_link_type       head,
   output logic                         pop,
   input  logic [peta_pkg::LIMIT_W-1:0] limit,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [2:0]                   out_status,
   output logic [191:0]                 out_data,
   output logic                         out_last
);
   import peta_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD = 2'd1;
   localparam logic [1:0] S_EV = 2'd2;
   localparam logic [1:0] S_OUT = 2'd3;

   logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
   logic [ACCT_W-1:0] acct_mem [TABLE_DEPTH];
   logic [PAY_W-1:0] pay_mem [TABLE_DEPTH];
   logic [TICK_W-1:0] arr_mem [TABLE_DEPTH];
   logic [TICK_W-1:0] stamp_mem [TABLE_DEPTH];

   logic [KEY_W-1:0] rd_key_ff;
   logic [ACCT_W-1:0] rd_acct_ff;
   logic [PAY_W-1:0] rd_pay_ff;
   logic [TICK_W-1:0] rd_arr_ff;
   logic [TICK_W-1:0] rd_stamp_ff;

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [1:0] state_ff, state_in;
   cmd_type cur_ff, cur_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [TICK_W-1:0] ins_cnt_ff, ins_cnt_in;
   logic [CNT_W-1:0] owned_ff, owned_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic free_found_ff, free_found_in;
   logic [AW-1:0] free_slot_ff, free_slot_in;
   logic dup_ff, dup_in;
   logic sel_found_ff, sel_found_in;
   logic [AW-1:0] sel_slot_ff, sel_slot_in;
   logic [KEY_W-1:0] sel_key_ff, sel_key_in;
   logic [ACCT_W-1:0] sel_acct_ff, sel_acct_in;
   logic [PAY_W-1:0] sel_pay_ff, sel_pay_in;
   logic [TICK_W-1:0] sel_arr_ff, sel_arr_in;
   logic [TICK_W-1:0] sel_age_ff, sel_age_in;

   logic out_valid_ff, out_valid_in;
   logic [2:0] out_status_ff, out_status_in;
   logic [191:0] out_data_ff, out_data_in;
   logic out_last_ff, out_last_in;

   logic v, kmatch, expired, take, out_free, wr_en, clr;
   logic [TICK_W-1:0] age;

   assign out_valid = out_valid_ff;
   assign out_status = out_status_ff;
   assign out_data = out_data_ff;
   assign out_last = out_last_ff;

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[idx_ff];
      rd_acct_ff <= acct_mem[idx_ff];
      rd_pay_ff <= pay_mem[idx_ff];
      rd_arr_ff <= arr_mem[idx_ff];
      rd_stamp_ff <= stamp_mem[idx_ff];
      if (wr_en) begin
         key_mem[free_slot_ff] <= cur_ff.key;
         acct_mem[free_slot_ff] <= cur_ff.account;
         pay_mem[free_slot_ff] <= cur_ff.payload;
         arr_mem[free_slot_ff] <= cur_ff.now;
         stamp_mem[free_slot_ff] <= ins_cnt_ff;
      end
   end

   always_comb begin
      v = valid_ff[idx_ff];
      kmatch = (rd_key_ff == cur_ff.key);
      expired = v && (rd_arr_ff < cur_ff.cutoff);
      age = ins_cnt_ff - rd_stamp_ff;
      out_free = !out_valid_ff || out_ready;
      if (cur_ff.action == ACT_AGE) begin
         take = expired && (!sel_found_ff || rd_arr_ff < sel_arr_ff ||
                (rd_arr_ff == sel_arr_ff && age > sel_age_ff));
      end else begin
         take = v && kmatch && !sel_found_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      idx_in = idx_ff;
      valid_in = valid_ff;
      ins_cnt_in = ins_cnt_ff;
      owned_in = owned_ff;
      cnt_in = cnt_ff;
      free_found_in = free_found_ff;
      free_slot_in = free_slot_ff;
      dup_in = dup_ff;
      sel_found_in = sel_found_ff;
      sel_slot_in = sel_slot_ff;
      sel_key_in = sel_key_ff;
      sel_acct_in = sel_acct_ff;
      sel_pay_in = sel_pay_ff;
      sel_arr_in = sel_arr_ff;
      sel_age_in = sel_age_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_status_in = out_status_ff;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      pop = 1'b0;
      wr_en = 1'b0;
      clr = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               cur_in = head.cmd;
               clr = 1'b1;
            end
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            if (cur_ff.action == ACT_INSERT) begin
               if (v) begin
                  if (rd_acct_ff == cur_ff.account) begin
                     owned_in = owned_ff + 1'b1;
                  end
                  if (kmatch) begin
                     dup_in = 1'b1;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in = idx_ff;
               end
            end else begin
               if (expired && cur_ff.action == ACT_AGE) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (take) begin
                  sel_found_in = 1'b1;
                  sel_slot_in = idx_ff;
                  sel_key_in = rd_key_ff;
                  sel_acct_in = rd_acct_ff;
                  sel_pay_in = rd_pay_ff;
                  sel_arr_in = rd_arr_ff;
                  sel_age_in = age;
               end
            end
            if (idx_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = S_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_last_in = 1'b1;
               out_data_in = '0;
               out_status_in = ST_DONE;
               state_in = S_IDLE;
               case (cur_ff.action)
                  ACT_INSERT: begin
                     if (!free_found_ff) begin
                        out_status_in = ST_FULL;
                     end else if (owned_ff >= limit) begin
                        out_status_in = ST_LIMIT;
                     end else if (dup_ff) begin
                        out_status_in = ST_DUP;
                     end else begin
                        wr_en = 1'b1;
                        valid_in[free_slot_ff] = 1'b1;
                        ins_cnt_in = ins_cnt_ff + 1'b1;
                     end
                  end
                  ACT_REMOVE, ACT_QUERY: begin
                     if (!sel_found_ff) begin
                        out_status_in = ST_NOT_FOUND;
                     end else begin
                        out_data_in = {sel_arr_ff, sel_pay_ff, sel_acct_ff, sel_key_ff};
                        if (cur_ff.action == ACT_REMOVE) begin
                           valid_in[sel_slot_ff] = 1'b0;
                        end
                     end
                  end
                  default: begin
                     if (cnt_ff == '0) begin
                        out_status_in = ST_NONE_EXPIRED;
                     end else begin
                        out_data_in = {sel_arr_ff, sel_pay_ff, sel_acct_ff, sel_key_ff};
                        valid_in[sel_slot_ff] = 1'b0;
                        if (cnt_ff != CNT_W'(1)) begin
                           out_last_in = 1'b0;
                           clr = 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (clr) begin
         state_in = S_RD;
         idx_in = '0;
         owned_in = '0;
         cnt_in = '0;
         free_found_in = 1'b0;
         dup_in = 1'b0;
         sel_found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      free_slot_ff <= free_slot_in;
      sel_slot_ff <= sel_slot_in;
      sel_key_ff <= sel_key_in;
      sel_acct_ff <= sel_acct_in;
      sel_pay_ff <= sel_pay_in;
      sel_arr_ff <= sel_arr_in;
      sel_age_ff <= sel_age_in;
      out_status_ff <= out_status_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      owned_ff <= owned_in;
      cnt_ff <= cnt_in;
      dup_ff <= dup_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         ins_cnt_ff <= '0;
         free_found_ff <= 1'b0;
         sel_found_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         ins_cnt_ff <= ins_cnt_in;
         free_found_ff <= free_found_in;
         sel_found_ff <= sel_found_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== hdl/pending_entry_table_with_aging_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_entry_table_with_aging_unit
// Pending entry table with per-owner quota and age-out, top level.
//
//   channel  direction  content
//   req_     in         command: action in tuser, key/owner/handle/ticks
//   rsp_     out        result: status in tuser, entry data, tlast
//   csr_     in         per-owner limit register at address 0
//
// Every command makes a full scan of the table, reading then evaluating each
// slot; age out repeats the scan once per expired entry.
// A two-entry command queue takes transfers while the back end is busy.
// Reset clears valid bits, queue and counter and sets the limit to 8.
// A stalled rsp_ holds the scan in its output step.
// ----------------------------------------------------------------------------
module pending_entry_table_with_aging_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // action
   input  logic [223:0] req_tdata,   // entry_key, owner_account, payload_handle,
                                     // now_tick, max_age
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,   // status
   output logic [191:0] rsp_tdata,   // out_key, out_account, out_payload,
                                     // out_arrival
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import peta_pkg::*;

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   cmd_link_type head;
   logic pop;
   logic sel0;

   assign csr_pready = 1'b1;
   assign sel0 = (csr_paddr[2] == 1'b0);
   assign csr_prdata = sel0 ? {25'd0, limit_ff} : 32'd0;

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel0) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   peta_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_action (req_tuser),
      .in_data   (req_tdata),
      .head      (head),
      .pop       (pop)
   );

   peta_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .limit      (limit_ff),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (rsp_tuser),
      .out_data   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule
